### rtl/core/smx_pkg.sv
`default_nettype none
package smx_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int MEM_DEPTH   = 256;
	localparam int STACK_AW    = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int MEM_AW      = $clog2(MEM_DEPTH);
	localparam int DATA_W      = 32;
	localparam int PC_W        = 16;
	localparam logic [PC_W-1:0] PC_RESET = 16'd2;

	typedef enum logic [7:0] {
		OP_ADD  = 8'd0,
		OP_SUB  = 8'd1,
		OP_MUL  = 8'd2,
		OP_DIV  = 8'd3,
		OP_LT   = 8'd4,
		OP_GT   = 8'd5,
		OP_EQ   = 8'd6,
		OP_LE   = 8'd7,
		OP_GE   = 8'd8,
		OP_AND  = 8'd9,
		OP_OR   = 8'd10,
		OP_XOR  = 8'd11,
		OP_DUP  = 8'd12,
		OP_ROT  = 8'd13,
		OP_LIT  = 8'd14,
		OP_LOAD = 8'd15,
		OP_SAVE = 8'd16,
		OP_OUT  = 8'd17,
		OP_IN   = 8'd18,
		OP_JNZ  = 8'd19,
		OP_JMP  = 8'd20,
		OP_NOP  = 8'd21,
		OP_HALT = 8'd22
	} op_t;

	typedef enum logic [2:0] {
		STS_RUN   = 3'd0,
		STS_HALT  = 3'd1,
		STS_END   = 3'd2,
		STS_BADOP = 3'd3,
		STS_STACK = 3'd4,
		STS_ADDR  = 3'd5,
		STS_DIV0  = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_RD,
		CS_EX,
		CS_DIV,
		CS_FIN,
		CS_SWAP
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic div_start;
		logic commit;
		logic swap2;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic need_swap;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

### rtl/core/smx_ifs.sv
`default_nettype none
interface smx_in_if;
	import smx_pkg::*;
	logic              valid;
	logic              ready;
	logic [7:0]        command;
	logic [DATA_W-1:0] argument;
	logic [DATA_W-1:0] console_value;
	modport source (output valid, command, argument, console_value, input ready);
	modport sink (input valid, command, argument, console_value, output ready);
endinterface

interface smx_out_if;
	import smx_pkg::*;
	logic              valid;
	logic              ready;
	logic [PC_W-1:0]   next_pc;
	logic              out_valid;
	logic [DATA_W-1:0] out_value;
	logic [2:0]        status;
	modport source (output valid, next_pc, out_valid, out_value, status, input ready);
	modport sink (input valid, next_pc, out_valid, out_value, status, output ready);
endinterface
`default_nettype wire

### rtl/core/smx_div.sv
`default_nettype none
module smx_div
	import smx_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DATA_W-1:0] a,
	input  wire logic [DATA_W-1:0] b,
	output logic                   done,
	output logic [DATA_W-1:0]      q
);

	logic                      run_q;
	logic                      done_q;
	logic [$clog2(DATA_W)-1:0] cnt_q;
	logic                      neg_q;
	logic [DATA_W-1:0]         mb_q;
	logic [DATA_W-1:0]         rem_q;
	logic [DATA_W-1:0]         quo_q;
	logic [DATA_W:0]           trial;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[DATA_W-1]} - {1'b0, mb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= a[DATA_W-1] ^ b[DATA_W-1];
			mb_q  <= b[DATA_W-1] ? (DATA_W'(0) - b) : b;
			quo_q <= a[DATA_W-1] ? (DATA_W'(0) - a) : a;
			rem_q <= '0;
		end else if (run_q) begin
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign q    = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule
`default_nettype wire

### rtl/core/smx_dp.sv
`default_nettype none
module smx_dp
	import smx_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	input  wire logic [7:0]        in_command,
	input  wire logic [DATA_W-1:0] in_argument,
	input  wire logic [DATA_W-1:0] in_console_value,
	input  wire logic              cfg_we,
	input  wire logic [PC_W-1:0]   cfg_data,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output logic [PC_W-1:0]        res_next_pc,
	output logic                   res_out_valid,
	output logic [DATA_W-1:0]      res_out_value,
	output logic [2:0]             res_status
);

	logic [DATA_W-1:0] stk [STACK_DEPTH];
	logic [DATA_W-1:0] dmem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] dvalid_q;

	logic [7:0]         cmd_q;
	logic [DATA_W-1:0]  arg_q;
	logic [DATA_W-1:0]  con_q;
	logic [DEPTH_W-1:0] d_q;
	logic [PC_W-1:0]    pc_q;
	logic               halt_q;
	logic [PC_W-1:0]    len_q;
	logic [DATA_W-1:0]  s1_q;
	logic [DATA_W-1:0]  s2_q;
	logic [DATA_W-1:0]  dm_q;
	logic               dv_q;

	logic               ov_q;
	logic [DATA_W-1:0]  oval_q;
	logic [PC_W-1:0]    opc_q;
	logic [2:0]         osts_q;

	logic [STACK_AW-1:0] idx_top, idx_sec, idx_push;
	logic [MEM_AW-1:0]   midx;
	logic [DATA_W-1:0]   a, b, r, dm_rd, div_q;
	logic                div_done;
	logic [PC_W:0]       pc_inc;
	logic [PC_W-1:0]     npc;
	logic                addr_ok, full, d_ge1, d_ge2, active;
	status_t             st;
	logic [PC_W-1:0]     pc_n;
	logic                halt_n;
	logic [DEPTH_W-1:0]  d_n;
	logic                stk_we, dm_we, ov;
	logic [STACK_AW-1:0] stk_wa;
	logic [DATA_W-1:0]   stk_wd, dm_wd, oval;
	logic                w_en;
	logic [STACK_AW-1:0] w_a;
	logic [DATA_W-1:0]   w_d;

	assign idx_top  = STACK_AW'(d_q - DEPTH_W'(1));
	assign idx_sec  = STACK_AW'(d_q - DEPTH_W'(2));
	assign idx_push = STACK_AW'(d_q);
	assign midx     = arg_q[MEM_AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_command;
			arg_q <= in_argument;
			con_q <= in_console_value;
		end
		if (cmd.rd) begin
			s1_q <= stk[idx_top];
			s2_q <= stk[idx_sec];
			dm_q <= dmem[midx];
			dv_q <= dvalid_q[midx];
		end
	end

	smx_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.a      (s2_q),
		.b      (s1_q),
		.done   (div_done),
		.q      (div_q)
	);

	assign a     = s2_q;
	assign b     = s1_q;
	assign dm_rd = dv_q ? dm_q : '0;
	assign full  = d_q >= DEPTH_W'(STACK_DEPTH);
	assign d_ge1 = d_q != '0;
	assign d_ge2 = d_q >= DEPTH_W'(2);
	assign addr_ok = arg_q < DATA_W'(MEM_DEPTH);
	assign active  = !halt_q && (pc_q < len_q);
	assign pc_inc  = {1'b0, pc_q} + ((cmd_q <= OP_ROT) ? (PC_W+1)'(1) : (PC_W+1)'(2));
	assign npc     = pc_inc[PC_W] ? '1 : pc_inc[PC_W-1:0];

	always_comb begin
		case (cmd_q)
			OP_ADD:  r = a + b;
			OP_SUB:  r = a - b;
			OP_MUL:  r = a * b;
			OP_DIV:  r = div_q;
			OP_LT:   r = DATA_W'($signed(a) < $signed(b));
			OP_GT:   r = DATA_W'($signed(b) < $signed(a));
			OP_EQ:   r = DATA_W'(a == b);
			OP_LE:   r = DATA_W'(!($signed(b) < $signed(a)));
			OP_GE:   r = DATA_W'(!($signed(a) < $signed(b)));
			OP_AND:  r = a & b;
			OP_OR:   r = a | b;
			default: r = a ^ b;
		endcase
	end

	always_comb begin
		st     = STS_RUN;
		pc_n   = pc_q;
		halt_n = halt_q;
		d_n    = d_q;
		stk_we = 1'b0;
		stk_wa = idx_push;
		stk_wd = arg_q;
		dm_we  = 1'b0;
		dm_wd  = con_q;
		ov     = 1'b0;
		oval   = '0;
		pc_n   = pc_q;
		if (halt_q) begin
			st = STS_HALT;
		end else if (pc_q >= len_q) begin
			st     = STS_END;
			halt_n = 1'b1;
		end else begin
			pc_n = npc;
			case (cmd_q) inside
				[OP_ADD:OP_XOR]: begin
					if (!d_ge2) begin
						st = STS_STACK;
					end else if (cmd_q == OP_DIV && b == '0) begin
						st = STS_DIV0;
					end else begin
						stk_we = 1'b1;
						stk_wa = idx_sec;
						stk_wd = r;
						d_n    = d_q - DEPTH_W'(1);
					end
				end
				OP_DUP: begin
					if (!d_ge1 || full) begin
						st = STS_STACK;
					end else begin
						stk_we = 1'b1;
						stk_wd = b;
						d_n    = d_q + DEPTH_W'(1);
					end
				end
				OP_ROT: begin
					// top gets the second entry here, the second gets the top next cycle
					if (!d_ge2) begin
						st = STS_STACK;
					end else begin
						stk_we = 1'b1;
						stk_wa = idx_top;
						stk_wd = a;
					end
				end
				OP_LIT: begin
					if (full) begin
						st = STS_STACK;
					end else begin
						stk_we = 1'b1;
						d_n    = d_q + DEPTH_W'(1);
					end
				end
				OP_LOAD: begin
					if (full) begin
						st = STS_STACK;
					end else if (!addr_ok) begin
						st = STS_ADDR;
					end else begin
						stk_we = 1'b1;
						stk_wd = dm_rd;
						d_n    = d_q + DEPTH_W'(1);
					end
				end
				OP_SAVE: begin
					if (!d_ge1) begin
						st = STS_STACK;
					end else if (!addr_ok) begin
						st = STS_ADDR;
					end else begin
						dm_we = 1'b1;
						dm_wd = b;
						d_n   = d_q - DEPTH_W'(1);
					end
				end
				OP_OUT: begin
					if (!addr_ok) begin
						st = STS_ADDR;
					end else begin
						ov   = 1'b1;
						oval = dm_rd;
					end
				end
				OP_IN: begin
					if (!addr_ok) st = STS_ADDR;
					else dm_we = 1'b1;
				end
				OP_JNZ: begin
					if (!d_ge1) st = STS_STACK;
					else if (b != '0) pc_n = arg_q[PC_W-1:0];
				end
				OP_JMP: pc_n = arg_q[PC_W-1:0];
				OP_NOP: ;
				OP_HALT: st = STS_HALT;
				default: st = STS_BADOP;
			endcase
			if (st == STS_HALT) begin
				halt_n = 1'b1;
			end else if (st == STS_RUN) begin
				if (pc_n >= len_q) begin
					halt_n = 1'b1;
					st     = STS_END;
				end
			end else begin
				// faults leave everything but the halted flag
				halt_n = 1'b1;
				pc_n   = pc_q;
				d_n    = d_q;
				stk_we = 1'b0;
				dm_we  = 1'b0;
				ov     = 1'b0;
				oval   = '0;
			end
		end
	end

	assign sts.need_div  = active && cmd_q == OP_DIV && d_ge2 && b != '0;
	assign sts.need_swap = active && cmd_q == OP_ROT && d_ge2;
	assign sts.div_done  = div_done;
	assign sts.out_free  = !res_valid || res_ready;

	assign w_en = (cmd.commit && stk_we) || cmd.swap2;
	assign w_a  = cmd.swap2 ? idx_sec : stk_wa;
	assign w_d  = cmd.swap2 ? b : stk_wd;

	always_ff @(posedge clk) begin
		if (w_en) stk[w_a] <= w_d;
		if (cmd.commit && dm_we) dmem[midx] <= dm_wd;
		if (cmd.commit) begin
			opc_q  <= pc_n;
			ov_q   <= ov;
			oval_q <= oval;
			osts_q <= st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q      <= '0;
			pc_q     <= PC_RESET;
			halt_q   <= 1'b0;
			len_q    <= '0;
			dvalid_q <= '0;
			res_valid <= 1'b0;
		end else begin
			if (cfg_we) len_q <= cfg_data;
			if (cmd.commit) begin
				d_q    <= d_n;
				pc_q   <= pc_n;
				halt_q <= halt_n;
				if (dm_we) dvalid_q[midx] <= 1'b1;
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	assign res_next_pc   = opc_q;
	assign res_out_valid = ov_q;
	assign res_out_value = oval_q;
	assign res_status    = osts_q;

endmodule
`default_nettype wire

### rtl/core/smx_ctrl.sv
`default_nettype none
module smx_ctrl
	import smx_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= CS_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = CS_RD;
				end
			end
			CS_RD: begin
				cmd.rd  = 1'b1;
				state_d = CS_EX;
			end
			CS_EX: begin
				if (sts.need_div) begin
					cmd.div_start = 1'b1;
					state_d       = CS_DIV;
				end else if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = sts.need_swap ? CS_SWAP : CS_IDLE;
				end
			end
			CS_DIV: begin
				if (sts.div_done) state_d = CS_FIN;
			end
			CS_FIN: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = CS_IDLE;
				end
			end
			CS_SWAP: begin
				cmd.swap2 = 1'b1;
				state_d   = CS_IDLE;
			end
			default: state_d = CS_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_load_then_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == CS_RD)
		else $error("transfer not followed by operand read");
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("commit while result register occupied");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> state_q == CS_DIV && !cmd.commit)
		else $error("divide start did not enter wait");
	a_swap_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.swap2 |-> $past(cmd.commit))
		else $error("second swap write without commit");
`endif

endmodule
`default_nettype wire

### rtl/core/stack_machine_execute.sv
`default_nettype none
// executes one stack machine instruction per input transfer and returns one result
// (next pc, optional output word, status). each instruction steps through load, operand
// read from stack and data memory, and execute, which waits while the output register
// is still occupied; swap adds a second stack write, and divide waits on the bit-serial
// divider. a new instruction is taken once the previous one has executed, while its
// result may still wait in the output register. program_length must be written through
// cfg_we/cfg_data only while no instruction is in flight; the block does not enforce this.
module stack_machine_execute
	import smx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	smx_in_if.sink           in_ch,
	smx_out_if.source        out_ch,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;
	logic in_rdy;

	smx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_rdy),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign in_ch.ready = in_rdy;

	smx_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_command       (in_ch.command),
		.in_argument      (in_ch.argument),
		.in_console_value (in_ch.console_value),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data),
		.res_valid        (out_ch.valid),
		.res_ready        (out_ch.ready),
		.res_next_pc      (out_ch.next_pc),
		.res_out_valid    (out_ch.out_valid),
		.res_out_value    (out_ch.out_value),
		.res_status       (out_ch.status)
	);

endmodule
`default_nettype wire

### verif/stack_machine_execute_checker.sv
`timescale 1ns / 1ps
module stack_machine_execute_checker
	import smx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	smx_in_if                in_ch,
	smx_out_if               out_ch,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data,
	output int               fails,
	output int               checked,
	output int               pending
);

	typedef struct packed {
		logic [PC_W-1:0]   next_pc;
		logic              out_valid;
		logic [DATA_W-1:0] out_value;
		status_t           status;
	} exec_result_t;

	logic [DATA_W-1:0] vm_stack [STACK_DEPTH];
	logic [DATA_W-1:0] vm_mem [MEM_DEPTH];
	int unsigned       vm_depth = 0;
	logic [PC_W-1:0]   vm_pc = PC_RESET;
	logic              vm_halted = 1'b0;
	logic [15:0]       vm_length = '0;
	exec_result_t      expected_results[$];

	initial begin
		fails = 0;
		checked = 0;
		pending = 0;
		for (int i = 0; i < MEM_DEPTH; i++) vm_mem[i] = '0;
	end

	function automatic logic [DATA_W-1:0] signed_quotient(logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b);
		logic [DATA_W-1:0] ma, mb, q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	task automatic execute(input logic [7:0] cmd, input logic [DATA_W-1:0] arg,
			input logic [DATA_W-1:0] con);
		exec_result_t r;
		logic [DATA_W-1:0] a, b, v;
		logic [16:0] npc;
		logic addr_ok;
		r = '0;
		r.status = STS_RUN;
		if (vm_halted) begin
			r.status = STS_HALT;
		end else if (vm_pc >= vm_length) begin
			vm_halted = 1'b1;
			r.status = STS_END;
		end else begin
			npc = vm_pc + ((cmd <= OP_ROT) ? 17'd1 : 17'd2);
			if (npc > 17'hFFFF) npc = 17'hFFFF;
			addr_ok = arg < MEM_DEPTH;
			if (cmd <= OP_XOR) begin
				if (vm_depth < 2) begin
					r.status = STS_STACK;
				end else begin
					b = vm_stack[vm_depth-1];
					a = vm_stack[vm_depth-2];
					v = '0;
					case (cmd)
						OP_ADD: v = a + b;
						OP_SUB: v = a - b;
						OP_MUL: v = a * b;
						OP_DIV: begin
							if (b == 0) r.status = STS_DIV0;
							else v = signed_quotient(a, b);
						end
						OP_LT: v = ($signed(a) < $signed(b));
						OP_GT: v = ($signed(a) > $signed(b));
						OP_EQ: v = (a == b);
						OP_LE: v = ($signed(a) <= $signed(b));
						OP_GE: v = ($signed(a) >= $signed(b));
						OP_AND: v = a & b;
						OP_OR: v = a | b;
						default: v = a ^ b;
					endcase
					if (r.status == STS_RUN) begin
						vm_stack[vm_depth-2] = v;
						vm_depth--;
					end
				end
			end else begin
				case (cmd)
					OP_DUP: begin
						if (vm_depth < 1 || vm_depth >= STACK_DEPTH) r.status = STS_STACK;
						else begin
							vm_stack[vm_depth] = vm_stack[vm_depth-1];
							vm_depth++;
						end
					end
					OP_ROT: begin
						if (vm_depth < 2) r.status = STS_STACK;
						else begin
							v = vm_stack[vm_depth-1];
							vm_stack[vm_depth-1] = vm_stack[vm_depth-2];
							vm_stack[vm_depth-2] = v;
						end
					end
					OP_LIT: begin
						if (vm_depth >= STACK_DEPTH) r.status = STS_STACK;
						else begin
							vm_stack[vm_depth] = arg;
							vm_depth++;
						end
					end
					OP_LOAD: begin
						if (vm_depth >= STACK_DEPTH) r.status = STS_STACK;
						else if (!addr_ok) r.status = STS_ADDR;
						else begin
							vm_stack[vm_depth] = vm_mem[arg[MEM_AW-1:0]];
							vm_depth++;
						end
					end
					OP_SAVE: begin
						if (vm_depth < 1) r.status = STS_STACK;
						else if (!addr_ok) r.status = STS_ADDR;
						else begin
							vm_mem[arg[MEM_AW-1:0]] = vm_stack[vm_depth-1];
							vm_depth--;
						end
					end
					OP_OUT: begin
						if (!addr_ok) r.status = STS_ADDR;
						else begin
							r.out_valid = 1'b1;
							r.out_value = vm_mem[arg[MEM_AW-1:0]];
						end
					end
					OP_IN: begin
						if (!addr_ok) r.status = STS_ADDR;
						else vm_mem[arg[MEM_AW-1:0]] = con;
					end
					OP_JNZ: begin
						if (vm_depth < 1) r.status = STS_STACK;
						else if (vm_stack[vm_depth-1] != 0) npc = arg[15:0];
					end
					OP_JMP: npc = arg[15:0];
					OP_NOP: ;
					OP_HALT: r.status = STS_HALT;
					default: r.status = STS_BADOP;
				endcase
			end
			if (r.status == STS_RUN || r.status == STS_HALT) begin
				vm_pc = npc[15:0];
				if (r.status == STS_HALT) begin
					vm_halted = 1'b1;
				end else if (npc[15:0] >= vm_length) begin
					vm_halted = 1'b1;
					r.status = STS_END;
				end
			end else begin
				vm_halted = 1'b1;
			end
		end
		r.next_pc = vm_pc;
		expected_results.insert(expected_results.size(), r);
	endtask

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		fails++;
	endtask

	always @(posedge clk) begin
		exec_result_t e;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected, pc", out_ch.next_pc, 0);
				end else begin
					e = expected_results.pop_front();
					if (out_ch.next_pc !== e.next_pc)
						report_mismatch("next_pc", out_ch.next_pc, e.next_pc);
					if (out_ch.out_valid !== e.out_valid)
						report_mismatch("out_valid", out_ch.out_valid, e.out_valid);
					if (out_ch.out_value !== e.out_value)
						report_mismatch("out_value", out_ch.out_value, e.out_value);
					if (out_ch.status !== e.status)
						report_mismatch("status", out_ch.status, e.status);
				end
				checked <= checked + 1;
			end
			if (in_ch.valid && in_ch.ready)
				execute(in_ch.command, in_ch.argument, in_ch.console_value);
			if (cfg_we) vm_length = cfg_data;
			pending <= expected_results.size();
		end
	end

endmodule

### verif/tb_stack_machine_execute.sv
`timescale 1ns / 1ps
module tb_stack_machine_execute;
	import smx_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 240;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_data = '0;
	int          fails, checked, pending;
	int          cycles = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          hold_cnt = 0;
	logic        long_hold_req = 1'b0;
	logic        hold_done = 1'b0;
	int unsigned stack_level = 0;
	int          items_sent = 0;

	smx_in_if  in_ch();
	smx_out_if out_ch();

	stack_machine_execute dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	stack_machine_execute_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.fails(fails), .checked(checked), .pending(pending)
	);

	always #5 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.command = '0;
		in_ch.argument = '0;
		in_ch.console_value = '0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random stalls plus one long hold-off to back up the input
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			out_ch.ready <= 1'b0;
			hold_cnt--;
		end else if (long_hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_cnt = 300;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send(input logic [7:0] cmd, input logic [31:0] arg,
			input logic [31:0] con);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.argument <= arg;
		in_ch.console_value <= con;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
		case (cmd)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT, OP_EQ, OP_LE, OP_GE,
			OP_AND, OP_OR, OP_XOR, OP_SAVE: stack_level--;
			OP_DUP, OP_LIT, OP_LOAD: stack_level++;
			default: ;
		endcase
	endtask

	// drain everything in flight before touching the length register
	task automatic write_length(input logic [15:0] len);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 3) - 1;
			default: return $urandom();
		endcase
	endfunction

	// one well-formed instruction, or a literal divisor and a divide, chosen so the machine keeps running
	task automatic send_random_instruction();
		int pick;
		logic [7:0] cmd;
		pick = $urandom_range(99);
		if (stack_level >= STACK_DEPTH - 2) pick = 0;
		if (stack_level < 2 && pick < 50) pick = 50 + $urandom_range(49);
		if (pick < 35) begin
			cmd = (pick < 30) ? $urandom_range(OP_ADD, OP_XOR) : OP_SAVE;
			if (cmd == OP_DIV) cmd = OP_SUB;
			if (cmd == OP_SAVE) send(cmd, $urandom_range(MEM_DEPTH - 1), $urandom());
			else send(cmd, $urandom(), $urandom());
		end else if (pick < 50) begin
			// divide behind a nonzero literal divisor
			send(OP_LIT, ($urandom_range(1) ? rand_word() : $urandom_range(1, 9)) | 32'h1,
				$urandom());
			send(OP_DIV, $urandom(), $urandom());
		end else if (pick < 62) begin
			send(OP_LIT, rand_word(), $urandom());
		end else if (pick < 68) begin
			if (stack_level >= 1) send(OP_DUP, $urandom(), $urandom());
			else send(OP_LIT, rand_word(), $urandom());
		end else if (pick < 72) begin
			if (stack_level >= 2) send(OP_ROT, $urandom(), $urandom());
			else send(OP_NOP, $urandom(), $urandom());
		end else if (pick < 78) begin
			send(OP_LOAD, $urandom_range(MEM_DEPTH - 1), $urandom());
		end else if (pick < 84) begin
			send(OP_OUT, $urandom_range(MEM_DEPTH - 1), $urandom());
		end else if (pick < 90) begin
			send(OP_IN, $urandom_range(MEM_DEPTH - 1), $urandom());
		end else if (pick < 94) begin
			if (stack_level >= 1) send(OP_JNZ, $urandom_range(0, 40000), $urandom());
			else send(OP_NOP, $urandom(), $urandom());
		end else if (pick < 97) begin
			send(OP_JMP, $urandom_range(0, 40000), $urandom());
		end else begin
			send(OP_NOP, $urandom(), $urandom());
		end
	endtask

	// one way of stopping the machine for good, since reset is never repeated
	task automatic send_halting_case();
		case ($urandom_range(6))
			0: send($urandom_range(23, 255), $urandom(), $urandom());
			1: begin
				while (stack_level > 1) send(OP_XOR, 0, 0);
				if (stack_level == 0) send(OP_LIT, rand_word(), 0);
				send(OP_ADD, 0, 0);
			end
			2: send(OP_LOAD, $urandom_range(1) ? 32'd256 : 32'hFFFF_FFFF, 0);
			3: begin
				send(OP_LIT, 0, 0);
				send(OP_DIV, 0, 0);
			end
			4: send(OP_HALT, $urandom(), $urandom());
			5: send(OP_JMP, 32'hFFFF_FFFF, 0);
			default: begin
				write_length(16'd0);
				send(OP_NOP, 0, 0);
			end
		endcase
		repeat (6) send(OP_NOP + $urandom_range(4), $urandom(), $urandom());
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_length(16'd0);
		write_length(16'hFFFF);

		// directed: extremes and every non-halting operation
		send(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(OP_LIT, 32'h8000_0000, 32'h0);
		send(OP_LIT, 32'hFFFF_FFFF, 32'h0);
		send(OP_DIV, 0, 0);
		send(OP_LIT, 32'h7FFF_FFFF, 0);
		send(OP_LIT, 32'h7FFF_FFFF, 0);
		send(OP_MUL, 0, 0);
		send(OP_LIT, 32'h8000_0001, 0);
		send(OP_ADD, 0, 0);
		send(OP_LIT, 32'h7FFF_FFFF, 0);
		send(OP_SUB, 0, 0);
		send(OP_LIT, 32'h8000_0000, 0);
		for (int op = OP_LT; op <= OP_XOR; op++) begin
			send(OP_DUP, 0, 0);
			send(OP_ROT, 0, 0);
			send(op, 0, 0);
		end
		send(OP_IN, 32'd255, 32'h8000_0000);
		send(OP_IN, 32'd0, 32'h7FFF_FFFF);
		send(OP_OUT, 32'd255, 0);
		send(OP_LOAD, 32'd0, 0);
		send(OP_SAVE, 32'd254, 0);
		send(OP_OUT, 32'd254, 0);
		send(OP_JNZ, 32'hFFFF_0010, 0);
		send(OP_JMP, 32'h1234_0002, 0);

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 34 : 58) : 0;
			stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 34 : 58) : 0;
			write_length(phase == 0 ? 16'hFFFF : 16'($urandom_range(50000, 65534)));
			if (phase == 2) long_hold_req <= 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) send_random_instruction();
		end
		send_halting_case();
		in_ch.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("sent %0d instructions and checked %0d results over four traffic phases",
			items_sent, checked);
		$display("with a long output hold-off and one final halting condition");
		if (fails == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
